/* hdl/spq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, constants and helpers for the sorted pair priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef logic [IDX_W-1:0] slot_type;
   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] first;
      logic signed [VAL_W-1:0] second;
   } pair_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CMP   = 5'b00010,
      ST_WRITE = 5'b00100,
      ST_POP   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   function automatic slot_type prev_slot(input slot_type s);
      slot_type r;
      if (s == '0) begin
         r = slot_type'(DEPTH - 1);
      end else begin
         r = s - slot_type'(1);
      end
      return r;
   endfunction

   function automatic slot_type next_slot(input slot_type s);
      slot_type r;
      if (s == slot_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = s + slot_type'(1);
      end
      return r;
   endfunction

   // (head + count) mod DEPTH; the sum stays below 2*DEPTH
   function automatic slot_type tail_slot(input slot_type head, input count_type cnt);
      logic [CNT_W:0] sum;
      logic [CNT_W:0] wrapped;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, cnt};
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         wrapped = sum - (CNT_W + 1)'(DEPTH);
      end else begin
         wrapped = sum;
      end
      return wrapped[IDX_W-1:0];
   endfunction

   function automatic logic signed [VAL_W-1:0] pair_key(input pair_type p,
                                                        input logic by_first);
      logic signed [VAL_W-1:0] k;
      if (by_first) begin
         k = p.first;
      end else begin
         k = p.second;
      end
      return k;
   endfunction

endpackage
`default_nettype wire

/* hdl/sorted_pair_priority_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_pair_priority_queue_core
// Ring buffer of signed value pairs kept in ascending key order.
// ----------------------------------------------------------------------------
// A push walks back from the tail through a pair memory with a write port and
// one registered read port, one compare-and-shift per cycle, moving each stored
// word with a larger key up one slot; at a depth of 32 at most 31 words move. A
// pop reads the head word, and a push to a full queue or a pop from an empty one
// is rejected. A stalled result side holds a finished word in ST_DONE until the
// output register is free. One word is worked on at a time; req_stall is
// high until the result has been moved to the output register. csr_wr_data
// selects the key: 1 first value, 0 second value.
module sorted_pair_priority_queue_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic                             csr_wr_data,
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic                             req_opcode,
   input  wire logic signed [spq_pkg::VAL_W-1:0] req_first_value,
   input  wire logic signed [spq_pkg::VAL_W-1:0] req_second_value,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic                             rsp_accepted,
   output      logic signed [spq_pkg::VAL_W-1:0] rsp_out_first,
   output      logic signed [spq_pkg::VAL_W-1:0] rsp_out_second
);
   import spq_pkg::*;

   state_type state_ff, state_in;
   logic      order_ff, order_in;
   slot_type  head_ff, head_in;
   count_type fill_ff, fill_in;
   slot_type  slot_ff, slot_in;
   pair_type  item_ff, item_in;
   logic      res_acc_ff, res_acc_in;
   pair_type  res_pair_ff, res_pair_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_acc_ff, rsp_acc_in;
   pair_type  rsp_pair_ff, rsp_pair_in;

   pair_type  mem [DEPTH];
   pair_type  rd_data_ff;
   slot_type  rd_addr;
   logic      mem_we;
   slot_type  mem_waddr;
   pair_type  mem_wdata;

   logic      accept;
   logic      out_free;
   slot_type  prev_i;
   pair_type  req_pair;
   logic      shift_up;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign prev_i    = prev_slot(slot_ff);
   assign req_pair  = '{first: req_first_value, second: req_second_value};
   assign shift_up  = pair_key(rd_data_ff, order_ff) > pair_key(item_ff, order_ff);

   always_comb begin
      state_in     = state_ff;
      order_in     = order_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      item_in      = item_ff;
      res_acc_in   = res_acc_ff;
      res_pair_in  = res_pair_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_acc_in   = rsp_acc_ff;
      rsp_pair_in  = rsp_pair_ff;
      rd_addr      = head_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = item_ff;

      if (csr_wr_en) begin
         order_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in     = req_pair;
               res_pair_in = '0;
               slot_in     = tail_slot(head_ff, fill_ff);
               if (req_opcode == OP_PUSH) begin
                  if (fill_ff == count_type'(DEPTH)) begin
                     res_acc_in = 1'b0;
                     state_in   = ST_DONE;
                  end else if (fill_ff == '0) begin
                     state_in = ST_WRITE;
                  end else begin
                     rd_addr  = prev_slot(tail_slot(head_ff, fill_ff));
                     state_in = ST_CMP;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     res_acc_in = 1'b0;
                     state_in   = ST_DONE;
                  end else begin
                     rd_addr  = head_ff;
                     state_in = ST_POP;
                  end
               end
            end
         end
         ST_CMP: begin
            mem_we = 1'b1;
            if (shift_up) begin
               mem_wdata = rd_data_ff;
               slot_in   = prev_i;
               if (prev_i == head_ff) begin
                  state_in = ST_WRITE;
               end else begin
                  rd_addr = prev_slot(prev_i);
               end
            end else begin
               mem_wdata  = item_ff;
               fill_in    = fill_ff + count_type'(1);
               res_acc_in = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_WRITE: begin
            mem_we     = 1'b1;
            mem_wdata  = item_ff;
            fill_in    = fill_ff + count_type'(1);
            res_acc_in = 1'b1;
            state_in   = ST_DONE;
         end
         ST_POP: begin
            res_pair_in = rd_data_ff;
            res_acc_in  = 1'b1;
            fill_in     = fill_ff - count_type'(1);
            if (fill_ff == count_type'(1)) begin
               head_in = '0;
            end else begin
               head_in = next_slot(head_ff);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_acc_ff;
               rsp_pair_in  = res_pair_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      item_ff     <= item_in;
      res_acc_ff  <= res_acc_in;
      res_pair_ff <= res_pair_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_pair_ff <= rsp_pair_in;
   end

   // pair memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_out_first  = rsp_pair_ff.first;
   assign rsp_out_second = rsp_pair_ff.second;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= count_type'(DEPTH))
      else $error("fill count above depth");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (head_ff == '0))
      else $error("head not at slot 0 while empty");

   a_cmp_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (fill_ff != '0) && (fill_ff != count_type'(DEPTH)))
      else $error("insertion walk with empty or full queue");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished word not moved to output");

endmodule
`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_pair_priority_queue_core.
// Words from a pending list go through a bursty driver. A shadow sorted ring
// predicts every result as its word is accepted. A monitor stalls the result
// side on shifting patterns and checks each result field by field.
// ----------------------------------------------------------------------------
module tb;
   import spq_pkg::*;

   localparam int NUM_WORDS   = 1850;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;
   localparam int SETTLE      = 40;

   typedef enum logic [1:0] {K_WORD, K_CSR, K_DRAIN} kind_type;

   typedef struct {
      kind_type                kind;
      logic                    op;
      logic signed [VAL_W-1:0] first;
      logic signed [VAL_W-1:0] second;
      logic                    by_first;
   } action_type;

   typedef struct {
      logic                    accepted;
      logic signed [VAL_W-1:0] first;
      logic signed [VAL_W-1:0] second;
   } reply_type;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    csr_wr_en        = 1'b0;
   logic                    csr_wr_data      = 1'b0;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic                    req_opcode       = OP_PUSH;
   logic signed [VAL_W-1:0] req_first_value  = '0;
   logic signed [VAL_W-1:0] req_second_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic                    rsp_accepted;
   logic signed [VAL_W-1:0] rsp_out_first;
   logic signed [VAL_W-1:0] rsp_out_second;

   sorted_pair_priority_queue_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_out_first    (rsp_out_first),
      .rsp_out_second   (rsp_out_second)
   );

   // shadow of the sorted ring
   pair_type ring [DEPTH];
   int       ring_head    = 0;
   int       ring_fill    = 0;
   logic     key_by_first = 1'b0;

   action_type pending_ops [$];
   reply_type  replies_due [$];

   int words_sent = 0, results_seen = 0;
   int burst_left = 0, gap_left = 0;
   int stall_mode = 0, stall_left = 0, mode_left = 0;
   int mismatches = 0;
   int pushes_stored = 0, pushes_full = 0, pops_done = 0, pops_empty = 0;
   int key_writes = 0;
   int gen_words = 0, gen_fill = 0;

   function automatic reply_type apply_word(input logic op,
                                            input logic signed [VAL_W-1:0] fv,
                                            input logic signed [VAL_W-1:0] sv);
      reply_type               r;
      int                      slot;
      int                      below;
      logic signed [VAL_W-1:0] new_key;
      logic signed [VAL_W-1:0] old_key;
      r = '{1'b0, '0, '0};
      if (op == OP_PUSH) begin
         if (ring_fill < DEPTH) begin
            new_key = key_by_first ? fv : sv;
            slot = (ring_head + ring_fill) % DEPTH;
            // equal keys stop the walk, so arrival order is kept
            while (slot != ring_head) begin
               below = (slot + DEPTH - 1) % DEPTH;
               old_key = key_by_first ? ring[below].first : ring[below].second;
               if (old_key <= new_key) break;
               ring[slot] = ring[below];
               slot = below;
            end
            ring[slot].first = fv;
            ring[slot].second = sv;
            ring_fill++;
            r.accepted = 1'b1;
         end
      end else if (ring_fill > 0) begin
         r = '{1'b1, ring[ring_head].first, ring[ring_head].second};
         ring_fill--;
         ring_head = (ring_fill == 0) ? 0 : (ring_head + 1) % DEPTH;
      end
      return r;
   endfunction

   task automatic flag(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("tb: mismatch %0d: %s", mismatches, msg);
      end
   endtask

   task automatic add_word(input logic op, input logic signed [VAL_W-1:0] f,
                           input logic signed [VAL_W-1:0] s);
      pending_ops.push_back('{K_WORD, op, f, s, 1'b0});
      gen_words++;
      if (op == OP_PUSH && gen_fill < DEPTH) begin
         gen_fill++;
      end else if (op == OP_POP && gen_fill > 0) begin
         gen_fill--;
      end
   endtask

   task automatic add_marker(input kind_type k, input logic by_first);
      pending_ops.push_back('{k, OP_PUSH, '0, '0, by_first});
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value(input int style);
      logic signed [VAL_W-1:0] v;
      case (style)
         0: v = $urandom;
         1: v = int'($urandom_range(0, 6)) - 3;
         default: begin
            case ($urandom_range(0, 4))
               0: v = {1'b0, {(VAL_W-1){1'b1}}};
               1: v = {1'b1, {(VAL_W-1){1'b0}}};
               2: v = '0;
               3: v = -1;
               default: v = 1;
            endcase
         end
      endcase
      return v;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: errors");
      $finish;
   end

   // driver: predicts on acceptance, control markers wait for an idle block
   always @(posedge clock) begin
      logic       nxt_valid;
      logic       nxt_wr;
      reply_type  r;
      action_type act;
      if (reset) begin
         req_valid <= 1'b0;
         csr_wr_en <= 1'b0;
      end else begin
         nxt_valid = req_valid;
         nxt_wr = 1'b0;
         if (req_valid && !req_stall) begin
            r = apply_word(req_opcode, req_first_value, req_second_value);
            replies_due.push_back(r);
            words_sent <= words_sent + 1;
            if (req_opcode == OP_PUSH) begin
               if (r.accepted) pushes_stored++; else pushes_full++;
            end else begin
               if (r.accepted) pops_done++; else pops_empty++;
            end
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && pending_ops.size() > 0) begin
            act = pending_ops[0];
            if (act.kind == K_WORD) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  void'(pending_ops.pop_front());
                  nxt_valid = 1'b1;
                  req_opcode <= act.op;
                  req_first_value <= act.first;
                  req_second_value <= act.second;
                  if (burst_left > 0) begin
                     burst_left--;
                  end else begin
                     burst_left = $urandom_range(1, 24);
                     gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                  end
               end
            end else if (!req_valid && words_sent == results_seen) begin
               if (act.kind == K_CSR) begin
                  nxt_wr = 1'b1;
                  csr_wr_data <= act.by_first;
                  key_by_first = act.by_first;
                  key_writes++;
               end
               void'(pending_ops.pop_front());
            end
         end
         req_valid <= nxt_valid;
         csr_wr_en <= nxt_wr;
      end
   end

   // monitor: checks results and stalls on a pattern that changes over time
   always @(posedge clock) begin
      reply_type want;
      logic      nxt_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (replies_due.size() == 0) begin
               flag($sformatf("unexpected word acc=%0d first=%0d second=%0d",
                              rsp_accepted, rsp_out_first, rsp_out_second));
            end else begin
               want = replies_due.pop_front();
               if (rsp_accepted !== want.accepted || rsp_out_first !== want.first ||
                   rsp_out_second !== want.second) begin
                  flag($sformatf("exp acc=%0d %0d/%0d, got acc=%0d %0d/%0d",
                                 want.accepted, want.first, want.second,
                                 rsp_accepted, rsp_out_first, rsp_out_second));
               end
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: nxt_stall = 1'b0;
            1: nxt_stall = ($urandom_range(0, 1) == 0);
            2: begin
               if (stall_left > 0) begin
                  stall_left--;
                  nxt_stall = 1'b1;
               end else begin
                  nxt_stall = 1'b0;
                  if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
               end
            end
            default: nxt_stall = (mode_left % 3 == 0);
         endcase
         rsp_stall <= nxt_stall;
      end
   end

   initial begin
      int                      seq;
      int                      style;
      int                      n;
      int                      push_pct;
      logic                    desc;
      logic signed [VAL_W-1:0] base;

      // directed
      add_word(OP_POP, '0, '0);
      add_marker(K_CSR, 1'b0);
      add_word(OP_PUSH, {1'b0, {(VAL_W-1){1'b1}}}, {1'b1, {(VAL_W-1){1'b0}}});
      add_word(OP_PUSH, {1'b1, {(VAL_W-1){1'b0}}}, {1'b0, {(VAL_W-1){1'b1}}});
      add_word(OP_PUSH, 0, 0);
      add_word(OP_PUSH, -1, 5);
      add_word(OP_PUSH, 7, 5);
      add_word(OP_PUSH, 3, -1);
      add_word(OP_POP, '0, '0);
      add_word(OP_POP, '0, '0);
      // key switched with entries still stored
      add_marker(K_CSR, 1'b1);
      add_word(OP_PUSH, 5, 9);
      add_word(OP_PUSH, {1'b1, {(VAL_W-1){1'b0}}}, 0);
      repeat (7) add_word(OP_POP, '0, '0);
      add_marker(K_DRAIN, 1'b0);

      // random
      while (gen_words < NUM_WORDS) begin
         seq = $urandom_range(0, 9);
         style = $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) add_marker(K_CSR, 1'($urandom_range(0, 1)));
         if (seq < 3) begin
            // fill to full or past it, then drain to empty or past it
            desc = 1'($urandom_range(0, 1));
            base = pick_value(style);
            n = DEPTH - gen_fill + $urandom_range(0, 3);
            for (int k = 0; k < n; k++) begin
               if (desc) add_word(OP_PUSH, base - k, base - k);
               else add_word(OP_PUSH, pick_value(style), pick_value(style));
            end
            if ($urandom_range(0, 2) == 0) add_marker(K_CSR, 1'($urandom_range(0, 1)));
            n = gen_fill + $urandom_range(0, 2);
            repeat (n) add_word(OP_POP, '0, '0);
         end else begin
            // mixed walk keeps the head moving around the ring
            push_pct = $urandom_range(30, 70);
            n = $urandom_range(10, 60);
            repeat (n) begin
               if ($urandom_range(0, 99) < push_pct) begin
                  add_word(OP_PUSH, pick_value(style), pick_value(style));
               end else begin
                  add_word(OP_POP, $urandom, $urandom);
               end
            end
            if (seq == 9) add_marker(K_DRAIN, 1'b0);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_valid || words_sent != results_seen) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
      if (replies_due.size() != 0) begin
         flag($sformatf("%0d results never arrived", replies_due.size()));
      end

      $display("tb: %0d words: %0d pushes stored, %0d refused full, %0d pops, %0d refused empty",
               words_sent, pushes_stored, pushes_full, pops_done, pops_empty);
      $display("tb: %0d key selections written, %0d results checked, %0d mismatches",
               key_writes, results_seen, mismatches);
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/spq_pkg.sv
hdl/sorted_pair_priority_queue_core.sv
sim/tb.sv
